@@ sv/spq_pkg.sv @@
// spq_pkg: shared types and status codes for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
`default_nettype none

package spq_pkg;

   localparam int PRI_W = 16;
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;

   typedef logic [PRI_W-1:0] pri_type;
   typedef logic signed [VAL_W-1:0] val_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // command broadcast from the top level to every cell
   typedef struct packed {
      logic    insert_en;
      logic    remove_en;
      pri_type pri;
      val_type val;
   } cmd_type;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// spq_cell: one slot of the sorted chain, holding a priority and value pair
// depends on spq_pkg; neighbors are wired together by sorted_priority_queue
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire cmd_type cmd,
   input  wire logic    valid,
   input  wire logic    left_take,
   input  wire pri_type left_pri,
   input  wire val_type left_val,
   input  wire pri_type right_pri,
   input  wire val_type right_val,
   output logic         take,
   output pri_type      pri,
   output val_type      val
);

   pri_type pri_ff, pri_in;
   val_type val_ff, val_in;

   // slot lies at or past the insert point: empty, or strictly greater priority
   assign take = !valid || (pri_ff > cmd.pri);

   always_comb begin
      pri_in = pri_ff;
      val_in = val_ff;
      if (cmd.insert_en) begin
         if (left_take) begin
            pri_in = left_pri;
            val_in = left_val;
         end else if (take) begin
            pri_in = cmd.pri;
            val_in = cmd.val;
         end
      end else if (cmd.remove_en) begin
         pri_in = right_pri;
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      val_ff <= val_in;
   end

   assign pri = pri_ff;
   assign val = val_ff;

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// sorted_priority_queue: bounded priority queue built as a chain of spq_cell slots
// depends on spq_pkg and spq_cell
// the result strobe is registered and comes in the cycle after the start transfer
// throughput: one operation per cycle; busy stays low, and all cells shift together
// reset clears the entry count and the result strobe; slot contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic [PRI_W-1:0]   req_priority_req,
   input  wire logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic [PRI_W-1:0]        rsp_out_priority,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             strobe_ff;
   status_type       status_ff, status_in;
   val_type          out_val_ff, out_val_in;
   pri_type          out_pri_ff, out_pri_in;

   logic    full, empty, is_insert, is_remove;
   cmd_type cmd;

   logic    cell_valid [DEPTH];
   logic    cell_take  [DEPTH];
   pri_type cell_pri   [DEPTH];
   val_type cell_val   [DEPTH];

   assign busy      = 1'b0;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign is_insert = start && (op_type'(req_operation) == OP_INSERT);
   assign is_remove = start && (op_type'(req_operation) == OP_REMOVE);

   assign cmd.insert_en = is_insert && !full;
   assign cmd.remove_en = is_remove && !empty;
   assign cmd.pri       = req_priority_req;
   assign cmd.val       = req_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic    left_take;
      pri_type left_pri, right_pri;
      val_type left_val, right_val;

      assign cell_valid[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_take = 1'b0;
         assign left_pri  = cmd.pri;
         assign left_val  = cmd.val;
      end else begin : g_mid
         assign left_take = cell_take[i-1];
         assign left_pri  = cell_pri[i-1];
         assign left_val  = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // tail slot goes out of range on a remove, its contents do not matter
         assign right_pri = '0;
         assign right_val = '0;
      end else begin : g_body
         assign right_pri = cell_pri[i+1];
         assign right_val = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .valid     (cell_valid[i]),
         .left_take (left_take),
         .left_pri  (left_pri),
         .left_val  (left_val),
         .right_pri (right_pri),
         .right_val (right_val),
         .take      (cell_take[i]),
         .pri       (cell_pri[i]),
         .val       (cell_val[i])
      );
   end

   always_comb begin
      count_in   = count_ff;
      status_in  = ST_OK;
      out_val_in = '0;
      out_pri_in = '0;
      if (is_insert) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (is_remove) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            count_in   = count_ff - CNT_W'(1);
            out_val_in = cell_val[0];
            out_pri_in = cell_pri[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= start;
      end
      status_ff  <= status_in;
      out_val_ff <= out_val_in;
      out_pri_ff <= out_pri_in;
   end

   logic [CNT_W+OCC_W-1:0] occ_ext;
   assign occ_ext = (CNT_W + OCC_W)'(count_ff);

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = out_val_ff;
   assign rsp_out_priority = out_pri_ff;
   assign rsp_occupancy    = occ_ext[OCC_W-1:0];

   // every transfer gives exactly one result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe)
      else $error("missing result after a start transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_strobe)
      else $error("result without a start transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (count_ff == CNT_W'(DEPTH)))
      else $error("full insert changed the entry count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |->
         (count_ff == '0 && rsp_out_value == '0 && rsp_out_priority == '0))
      else $error("empty remove returned data or changed the count");

endmodule

`default_nettype wire
